>>> hdl/dqne_pkg.sv
// ----------------------------------------------------------------------------
// DNS query name extractor package
// Shared constants, codes and the queue entry type of the name extractor.
// ----------------------------------------------------------------------------
package dqne_pkg;

  localparam int unsigned MaxNameLenDefault  = 128;
  localparam int unsigned UdpHdrBytesDefault = 8;
  localparam int unsigned DnsHdrBytes        = 12;
  localparam int unsigned FifoDepthDefault   = 4;

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] PrintLow  = 8'h20;
  localparam logic [7:0] PrintHigh = 8'h7E;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_REJECTED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_e;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       has_status;
    status_e    st;
  } entry_t;

endpackage

>>> hdl/dqne_front.sv
// ----------------------------------------------------------------------------
// DNS query name extractor front end
// Accepts payload bytes, tracks the header and label walk, and per byte
// queues at most one entry: its name character and, at packet end, the status.
// ----------------------------------------------------------------------------
module dqne_front #(
  parameter int unsigned MAX_NAME_LEN  = dqne_pkg::MaxNameLenDefault,
  parameter int unsigned UDP_HDR_BYTES = dqne_pkg::UdpHdrBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             full_i,
  input  logic [7:0]       data_byte_i,
  input  logic [15:0]      packet_length_i,
  input  logic             end_of_packet_i,
  output logic             push_o,
  output dqne_pkg::entry_t entry_o
);

  localparam logic [16:0] HdrEnd = 17'(UDP_HDR_BYTES + dqne_pkg::DnsHdrBytes);
  localparam logic [15:0] QrPos  = 16'(UDP_HDR_BYTES + 2);
  localparam logic [9:0]  MaxLen = 10'(MAX_NAME_LEN);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_DONE
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [15:0]       pos_q, pos_d;
  logic [6:0]        lrem_q, lrem_d;
  logic [7:0]        nlen_q, nlen_d;
  logic              first_q, first_d;
  dqne_pkg::status_e outcome_q, outcome_d;
  logic              fire;
  logic [9:0]        need;

  assign fire = in_valid_i && !full_i;
  assign need = {2'b0, nlen_q} + {9'b0, (nlen_q != 8'd0)} + {2'b0, data_byte_i};

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    lrem_d    = lrem_q;
    nlen_d    = nlen_q;
    first_d   = first_q;
    outcome_d = outcome_q;
    entry_o   = '0;
    case (phase_q)
      PH_HEADER: begin
        if ({1'b0, packet_length_i} < HdrEnd) begin
          outcome_d = dqne_pkg::ST_DROPPED;
          phase_d   = PH_DONE;
        end else if (pos_q == QrPos && data_byte_i[7]) begin
          outcome_d = dqne_pkg::ST_DROPPED;
          phase_d   = PH_DONE;
        end else if (({1'b0, pos_q} + 17'd1) >= HdrEnd) begin
          phase_d = PH_NAME;
          lrem_d  = '0;
          first_d = 1'b0;
          nlen_d  = '0;
        end else if (end_of_packet_i) begin
          outcome_d = dqne_pkg::ST_DROPPED;
          phase_d   = PH_DONE;
        end
      end
      PH_NAME: begin
        if (pos_q >= packet_length_i) begin
          phase_d = PH_DONE;
        end else if (lrem_q == 7'd0) begin
          if (data_byte_i == 8'd0 || data_byte_i[7] ||
              {8'd0, data_byte_i} >= packet_length_i) begin
            phase_d = PH_DONE;
          end else if (need > MaxLen) begin
            outcome_d = dqne_pkg::ST_REJECTED;
            phase_d   = PH_DONE;
          end else if (end_of_packet_i) begin
            phase_d = PH_DONE;
          end else begin
            if (nlen_q != 8'd0) begin
              entry_o.has_char = 1'b1;
              entry_o.ch       = dqne_pkg::DotChar;
              nlen_d           = nlen_q + 8'd1;
            end
            lrem_d  = data_byte_i[6:0];
            first_d = 1'b1;
          end
        end else begin
          if (first_q && (data_byte_i < dqne_pkg::PrintLow ||
                          data_byte_i > dqne_pkg::PrintHigh)) begin
            outcome_d = dqne_pkg::ST_REJECTED;
            phase_d   = PH_DONE;
          end else begin
            entry_o.has_char = 1'b1;
            entry_o.ch       = data_byte_i;
            nlen_d           = nlen_q + 8'd1;
            lrem_d           = lrem_q - 7'd1;
            first_d          = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end
    if (end_of_packet_i) begin
      entry_o.has_status = 1'b1;
      entry_o.st         = outcome_d;
      phase_d            = PH_HEADER;
      pos_d              = '0;
      lrem_d             = '0;
      nlen_d             = '0;
      first_d            = 1'b0;
      outcome_d          = dqne_pkg::ST_COMPLETE;
    end
  end

  assign push_o = fire && (entry_o.has_char || entry_o.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      lrem_q    <= '0;
      nlen_q    <= '0;
      first_q   <= 1'b0;
      outcome_q <= dqne_pkg::ST_COMPLETE;
    end else if (fire) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      lrem_q    <= lrem_d;
      nlen_q    <= nlen_d;
      first_q   <= first_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

>>> hdl/dqne_fifo.sv
// ----------------------------------------------------------------------------
// DNS query name extractor queue
// Short queue of entries between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module dqne_fifo #(
  parameter int unsigned DEPTH = dqne_pkg::FifoDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  dqne_pkg::entry_t           entry_i,
  input  logic                       pop_i,
  output dqne_pkg::entry_t           head_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  dqne_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == Full);
  assign count_o = count_q;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/dqne_back.sv
// ----------------------------------------------------------------------------
// DNS query name extractor result sequencer
// Splits each queue entry into its character item and status item and holds
// them in the output register.
// ----------------------------------------------------------------------------
module dqne_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dqne_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       name_char_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  logic              out_valid_q;
  logic              char_sent_q;
  dqne_pkg::kind_e   kind_q;
  logic [7:0]        char_q;
  dqne_pkg::status_e status_q;
  logic              load, take, emit_char;

  assign load      = !out_valid_q || !out_stall_i;
  assign take      = load && !empty_i;
  assign emit_char = head_i.has_char && !char_sent_q;
  assign pop_o     = take && !(emit_char && head_i.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      char_sent_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
      char_sent_q <= emit_char && head_i.has_status;
    end else if (load) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (emit_char) begin
        kind_q   <= dqne_pkg::KIND_CHAR;
        char_q   <= head_i.ch;
        status_q <= dqne_pkg::ST_COMPLETE;
      end else begin
        kind_q   <= dqne_pkg::KIND_STATUS;
        char_q   <= '0;
        status_q <= head_i.st;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign name_char_o   = char_q;
  assign status_o      = status_q;
  assign last_o        = (kind_q == dqne_pkg::KIND_STATUS);

endmodule

>>> hdl/dns_query_name_extractor.sv
// ----------------------------------------------------------------------------
// DNS query name extractor
// Walks the first question name of a DNS query carried in a UDP payload and
// emits it as dotted characters, followed by one status item per packet.
// ----------------------------------------------------------------------------
// One payload byte is accepted per cycle while the internal queue of
// FIFO_DEPTH entries has room. Each byte yields at most one name character
// and, on the final byte, one status item; results leave through a registered
// output at one item per cycle while out_stall_i is low, so a final byte that
// also carries a name character yields its character item before its status
// item. Each result passes through the queue and then the output register. The
// status is 0 for a complete name, 1 for a rejected name and 2 for a dropped
// packet; characters of a packet whose status is not 0 are to be discarded.
module dns_query_name_extractor #(
  parameter int unsigned MAX_NAME_LEN  = dqne_pkg::MaxNameLenDefault,
  parameter int unsigned UDP_HDR_BYTES = dqne_pkg::UdpHdrBytesDefault,
  parameter int unsigned FIFO_DEPTH    = dqne_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] packet_length_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  name_char_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  dqne_pkg::entry_t push_entry, head_entry;
  logic             push, pop, empty, full;
  logic [CntW-1:0]  count;

  assign in_stall_o = full;

  dqne_front #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .UDP_HDR_BYTES(UDP_HDR_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .full_i         (full),
    .data_byte_i    (data_byte_i),
    .packet_length_i(packet_length_i),
    .end_of_packet_i(end_of_packet_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  dqne_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head_entry),
    .empty_o(empty),
    .full_o (full),
    .count_o(count)
  );

  dqne_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .name_char_o  (name_char_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("An entry was pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("An entry was popped from an empty queue.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count == $past(count) + CntW'(1))
    else $error("The queue count did not follow a push.");

  a_status_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |-> (name_char_o == 8'd0 && last_o))
    else $error("A status item carries a name character.");
`endif

endmodule
